// ===== src/cst_pkg.sv =====
// Package for the counting semaphore table: payload structs, status codes, opcodes
// and default sizes. No dependencies.
package cst_pkg;
    localparam int NUM_SEMS_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_BITS_DEF   = 6;

    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_UNLINK = 2'd1;
    localparam logic [1:0] OP_WAIT   = 2'd2;
    localparam logic [1:0] OP_POST   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SLOT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] name_key;
        logic [14:0] init_value;
        logic [5:0]  sem_slot;
        logic [5:0]  task_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot_out;
        logic       blocked;
        logic       woken_valid;
        logic [5:0] woken_task;
    } t_out_word;
endpackage

// ===== src/counting_semaphore_table.sv =====
// Counting semaphore table: top level, one module.
// Depends on cst_pkg for payload structs, codes and default sizes.
//
// Usage: i_in_valid/o_in_ready take one command word (open, unlink, wait, post);
// o_out_valid/i_out_ready return one result word per command, in order.
// One command is in flight at a time. Slot state (key, count, head, tail) lives
// in a memory with a registered read port; the waiter queues live in a second one.
// Open and unlink scan the slot memory one entry a cycle, then pass S_WRD. Wait
// and post read, modify and write one slot in S_RD and S_MOD; a post that wakes a
// waiter also passes S_WRD for the waiter read. The result stays in an output
// register until taken; a new command is accepted only once the result has been taken.
// Reset clears the active bits (flip-flops) and the control state; the memories
// need no clearing since only active slots are read.
module counting_semaphore_table #(
    parameter int NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = cst_pkg::TASK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cst_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cst_pkg::t_out_word o_out_data
);
    import cst_pkg::*;

    localparam int SB = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QB = $clog2(QUEUE_DEPTH);
    localparam int QS = 1 << QB;
    localparam int CB = $clog2(NUM_SEMS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    typedef struct packed {
        logic [15:0]   key;
        logic [15:0]   count;
        logic [QB-1:0] head;
        logic [QB-1:0] tail;
    } t_slot;

    t_slot                r_mem [NUM_SEMS];
    logic [TASK_BITS-1:0] r_wq  [NUM_SEMS*QS];
    logic [NUM_SEMS-1:0]  r_active;

    logic [2:0]           r_state;
    t_in_word             r_cmd;
    logic [CB-1:0]        r_idx;
    logic                 r_rvld;
    logic [SB-1:0]        r_radr;
    t_slot                r_rd;
    logic                 r_free_fnd, r_key_fnd;
    logic [SB-1:0]        r_free_idx, r_key_idx;
    logic [TASK_BITS-1:0] r_wrd;
    t_out_word            r_out;

    logic                 w_we;
    logic [SB-1:0]        w_wadr;
    t_slot                w_wdat;
    logic                 w_qwe;
    logic [SB+QB-1:0]     w_qadr;

    logic [SB-1:0] w_slot;
    logic          w_slot_ok;
    logic signed [15:0] w_c;
    logic [QB-1:0] w_tn, w_hn;
    logic [SB+QB-1:0] w_qtail, w_qhead;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    assign w_slot    = SB'(r_cmd.sem_slot);
    assign w_slot_ok = ({3'b0, r_cmd.sem_slot} < 9'(NUM_SEMS)) && r_active[w_slot];
    assign w_c       = signed'(r_rd.count);
    assign w_tn      = (r_rd.tail == QB'(QUEUE_DEPTH - 1)) ? '0 : r_rd.tail + QB'(1);
    assign w_hn      = (r_rd.head == QB'(QUEUE_DEPTH - 1)) ? '0 : r_rd.head + QB'(1);
    assign w_qtail   = {w_slot, r_rd.tail};
    assign w_qhead   = {w_slot, r_rd.head};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wadr] <= w_wdat;
        end
        r_rd <= r_mem[(r_state == S_SCAN) ? r_idx[SB-1:0] : w_slot];
        if (w_qwe) begin
            r_wq[w_qadr] <= TASK_BITS'(r_cmd.task_id);
        end
        r_wrd <= r_wq[w_qhead];
    end

    always_comb begin
        w_we   = 1'b0;
        w_wadr = w_slot;
        w_wdat = r_rd;
        w_qwe  = 1'b0;
        w_qadr = w_qtail;
        if (r_state == S_WRD && !r_rvld && r_cmd.opcode == OP_OPEN
            && !r_key_fnd && r_free_fnd) begin
            w_we   = 1'b1;
            w_wadr = r_free_idx;
            w_wdat = '{key: r_cmd.name_key, count: {1'b0, r_cmd.init_value},
                       head: '0, tail: '0};
        end else if (r_state == S_MOD && w_slot_ok) begin
            if (r_cmd.opcode == OP_WAIT && w_c != -16'sd32768) begin
                if (w_c <= 0) begin
                    if (w_tn != r_rd.head) begin
                        w_we = 1'b1; w_qwe = 1'b1;
                        w_wdat.count = r_rd.count - 16'd1;
                        w_wdat.tail  = w_tn;
                    end
                end else begin
                    w_we = 1'b1;
                    w_wdat.count = r_rd.count - 16'd1;
                end
            end else if (r_cmd.opcode == OP_POST && w_c != 16'sd32767) begin
                if (w_c <= -16'sd1) begin
                    if (r_rd.head != r_rd.tail) begin
                        w_we = 1'b1;
                        w_wdat.count = r_rd.count + 16'd1;
                        w_wdat.head  = w_hn;
                    end
                end else begin
                    w_we = 1'b1;
                    w_wdat.count = r_rd.count + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_rvld   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd      <= i_in_data;
                        r_idx      <= '0;
                        r_rvld     <= 1'b0;
                        r_free_fnd <= 1'b0;
                        r_key_fnd  <= 1'b0;
                        r_out      <= '0;
                        r_state    <= (i_in_data.opcode == OP_OPEN ||
                                       i_in_data.opcode == OP_UNLINK) ? S_SCAN : S_RD;
                    end
                end
                S_SCAN: begin
                    if (r_rvld) begin
                        if (r_active[r_radr] && r_rd.key == r_cmd.name_key && !r_key_fnd) begin
                            r_key_fnd <= 1'b1;
                            r_key_idx <= r_radr;
                        end
                        if (!r_active[r_radr] && !r_free_fnd) begin
                            r_free_fnd <= 1'b1;
                            r_free_idx <= r_radr;
                        end
                    end
                    if (r_idx == CB'(NUM_SEMS)) begin
                        r_rvld <= 1'b0;
                        if (r_rvld) begin
                            r_rvld <= 1'b0;
                        end
                        r_state <= S_WRD;
                    end else begin
                        r_rvld <= 1'b1;
                        r_radr <= r_idx[SB-1:0];
                        r_idx  <= r_idx + CB'(1);
                    end
                end
                S_WRD: begin
                    if (r_cmd.opcode == OP_OPEN || r_cmd.opcode == OP_UNLINK) begin
                        if (r_rvld) begin
                            if (r_active[r_radr] && r_rd.key == r_cmd.name_key
                                && !r_key_fnd) begin
                                r_key_fnd <= 1'b1;
                                r_key_idx <= r_radr;
                            end
                            if (!r_active[r_radr] && !r_free_fnd) begin
                                r_free_fnd <= 1'b1;
                                r_free_idx <= r_radr;
                            end
                            r_rvld <= 1'b0;
                        end else begin
                            if (r_cmd.opcode == OP_UNLINK) begin
                                if (r_key_fnd) r_active[r_key_idx] <= 1'b0;
                            end else if (r_key_fnd) begin
                                r_out.slot_out <= 6'(r_key_idx);
                            end else if (r_free_fnd) begin
                                r_active[r_free_idx] <= 1'b1;
                                r_out.slot_out       <= 6'(r_free_idx);
                            end else begin
                                r_out.status <= ST_NO_SLOT;
                            end
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_out.woken_task <= 6'(r_wrd);
                        r_state <= S_OUT;
                    end
                end
                S_RD: r_state <= S_MOD;
                S_MOD: begin
                    r_state <= S_OUT;
                    if (w_slot_ok) begin
                        if (r_cmd.opcode == OP_WAIT) begin
                            if (w_c == -16'sd32768) r_out.status <= ST_OVERFLOW;
                            else if (w_c <= 0) begin
                                if (w_tn == r_rd.head) r_out.status <= ST_FULL;
                                else r_out.blocked <= 1'b1;
                            end
                        end else begin
                            if (w_c == 16'sd32767) r_out.status <= ST_OVERFLOW;
                            else if (w_c <= -16'sd1) begin
                                if (r_rd.head == r_rd.tail) r_out.status <= ST_EMPTY;
                                else begin
                                    r_out.woken_valid <= 1'b1;
                                    r_state <= S_WRD;
                                end
                            end
                        end
                    end
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for counting_semaphore_table: drives command words, predicts each result
// with a behavioral semaphore table, and compares results in order. Depends on cst_pkg.
module tb_top;
    import cst_pkg::*;

    localparam int NSEM = NUM_SEMS_DEF;
    localparam int QDEP = QUEUE_DEPTH_DEF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;

    counting_semaphore_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    // predictor state
    bit              sem_active [NSEM];
    logic [15:0]     sem_key    [NSEM];
    int              sem_cnt    [NSEM];
    int              q_head     [NSEM];
    int              q_tail     [NSEM];
    logic [5:0]      waiters    [NSEM*QDEP];

    t_in_word  cmd_queue [$];
    t_out_word expected_words [$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_sender;

    function automatic int find_slot(logic [15:0] key);
        for (int i = 0; i < NSEM; i++)
            if (sem_active[i] && sem_key[i] == key) return i;
        return -1;
    endfunction

    function automatic t_out_word apply_command(t_in_word w);
        t_out_word r;
        int i;
        int c;
        int h;
        int t;
        r = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_OPEN: begin
                i = find_slot(w.name_key);
                if (i < 0) begin
                    for (int k = NSEM - 1; k >= 0; k--)
                        if (!sem_active[k]) i = k;
                    if (i >= 0) begin
                        sem_active[i] = 1;
                        sem_key[i] = w.name_key;
                        sem_cnt[i] = w.init_value;
                        q_head[i] = 0;
                        q_tail[i] = 0;
                    end
                end
                if (i < 0) r.status = ST_NO_SLOT;
                else r.slot_out = i[5:0];
            end
            OP_UNLINK: begin
                i = find_slot(w.name_key);
                if (i >= 0) begin
                    sem_active[i] = 0;
                    sem_cnt[i] = 0;
                end
            end
            default: begin
                i = w.sem_slot;
                if (i < NSEM && sem_active[i]) begin
                    c = sem_cnt[i];
                    h = q_head[i];
                    t = q_tail[i];
                    if (w.opcode == OP_WAIT) begin
                        if (c <= -32768) r.status = ST_OVERFLOW;
                        else if (c - 1 < 0) begin
                            if ((t + 1) % QDEP == h) r.status = ST_FULL;
                            else begin
                                waiters[i*QDEP + t] = w.task_id;
                                q_tail[i] = (t + 1) % QDEP;
                                sem_cnt[i] = c - 1;
                                r.blocked = 1;
                            end
                        end else sem_cnt[i] = c - 1;
                    end else begin
                        if (c >= 32767) r.status = ST_OVERFLOW;
                        else if (c + 1 <= 0) begin
                            if (h == t) r.status = ST_EMPTY;
                            else begin
                                r.woken_task = waiters[i*QDEP + h];
                                r.woken_valid = 1;
                                q_head[i] = (h + 1) % QDEP;
                                sem_cnt[i] = c + 1;
                            end
                        end else sem_cnt[i] = c + 1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word make_cmd(logic [1:0] op, logic [15:0] key,
                                          logic [14:0] init, logic [5:0] slot,
                                          logic [5:0] tid);
        t_in_word w;
        w.opcode = op;
        w.name_key = key;
        w.init_value = init;
        w.sem_slot = slot;
        w.task_id = tid;
        return w;
    endfunction

    function automatic t_in_word rand_cmd();
        t_in_word w;
        int r;
        w = t_in_word'(45'({$urandom, $urandom}));
        r = $urandom_range(0, 99);
        w.name_key = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 11));
        if (r < 10)
            w.init_value = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                       : 15'($urandom_range(0, 3));
        if (r < 12) w.opcode = OP_OPEN;
        else if (r < 17) w.opcode = OP_UNLINK;
        else if (r < 60) w.opcode = OP_WAIT;
        else w.opcode = OP_POST;
        if ($urandom_range(0, 19) != 0) w.sem_slot = 6'($urandom_range(0, 13));
        return w;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in_data <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                expected_words.push_back(apply_command(i_in_data));
            if (cmd_queue.size() > 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1;
                i_in_data <= cmd_queue.pop_front();
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", o_out_data);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_out_data !== exp_w) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected st=%0d slot=%0d blk=%0d wv=%0d ",
                                      "wt=%0d, got st=%0d slot=%0d blk=%0d wv=%0d wt=%0d"},
                                exp_w.status, exp_w.slot_out, exp_w.blocked,
                                exp_w.woken_valid, exp_w.woken_task,
                                o_out_data.status, o_out_data.slot_out, o_out_data.blocked,
                                o_out_data.woken_valid, o_out_data.woken_task);
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) cmd_queue.push_back(rand_cmd());
        wait_drained();
    endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct = 33;
        recv_idle_pct = 55;
        hold_sender = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_ready = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed
        cmd_queue.push_back(make_cmd(OP_WAIT, 16'h0, 15'h0, 6'd0, 6'd1));
        cmd_queue.push_back(make_cmd(OP_OPEN, 16'hFFFF, 15'h7FFF, 6'd63, 6'd63));
        cmd_queue.push_back(make_cmd(OP_POST, 16'h0, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_OPEN, 16'hFFFF, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_OPEN, 16'h0000, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_POST, 16'h0, 15'h0, 6'd1, 6'd0));
        for (int k = 0; k < 16; k++)
            cmd_queue.push_back(make_cmd(OP_WAIT, 16'h0, 15'h0, 6'd1, 6'(k * 4 + 3)));
        cmd_queue.push_back(make_cmd(OP_POST, 16'h0, 15'h0, 6'd1, 6'd0));
        cmd_queue.push_back(make_cmd(OP_UNLINK, 16'h1234, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_UNLINK, 16'hFFFF, 15'h0, 6'd0, 6'd0));
        wait_drained();
        // fill table, then open with no free slot
        for (int k = 0; k < 65; k++)
            cmd_queue.push_back(make_cmd(OP_OPEN, 16'(16'h100 + k), 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_POST, 16'h0, 15'h0, 6'd63, 6'd0));
        hold_sender = 1;
        repeat (20) @(posedge i_clk);
        hold_sender = 0;
        wait_drained();
        // reuse: unlink key 0 (slot 1), reopen slot 1 as 16'hABCD at 15'h7FFE, then post three times to slot 0
        cmd_queue.push_back(make_cmd(OP_UNLINK, 16'h0000, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_OPEN, 16'hABCD, 15'h7FFE, 6'd0, 6'd0));
        for (int k = 0; k < 3; k++)
            cmd_queue.push_back(make_cmd(OP_POST, 16'h0, 15'h0, 6'd0, 6'd0));
        wait_drained();
        for (int k = 0; k < 64; k++)
            cmd_queue.push_back(make_cmd(OP_UNLINK, 16'(16'h100 + k), 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_UNLINK, 16'hABCD, 15'h0, 6'd0, 6'd0));
        cmd_queue.push_back(make_cmd(OP_UNLINK, 16'hFFFF, 15'h0, 6'd0, 6'd0));
        wait_drained();

        run_random(560);
        send_idle_pct = 55;
        recv_idle_pct = 33;
        run_random(560);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(570);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
